FILE: rtl/core/lzssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants for the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int DIST_W           = 12;
    localparam int LEN_W            = 4;
    localparam int COUNT_W          = 5;
    localparam int SIZE_W           = 16;
    localparam int FLAG_IDX_W       = 4;
    localparam logic [COUNT_W-1:0] LEN_BIAS = COUNT_W'(2);

    // Stream parse position within a resource.
    typedef enum logic [2:0] {
        PH_SIZE_LO = 3'd0,
        PH_SIZE_HI = 3'd1,
        PH_IGN_LO  = 3'd2,
        PH_IGN_HI  = 3'd3,
        PH_BODY    = 3'd4,
        PH_CTRL_HI = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    // Copy sequencer.
    typedef enum logic [1:0] {
        CP_IDLE = 2'd0,
        CP_READ = 2'd1,
        CP_EMIT = 2'd2
    } t_cp_state;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       starts_resource;
    } t_in_data;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       bad_reference;
    } t_out_data;

endpackage

FILE: rtl/core/lzssd_hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_hist_ram
// History window: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzssd_hist_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/lzss_stream_decompressor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top
// LZSS decompressor, 12-bit distance and 4-bit length, one byte in per
// transaction, decompressed bytes out one per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries compressed
//   bytes; starts_resource marks the first size byte of a resource.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries bytes
//   with last_byte on the final byte of the declared size and bad_reference
//   on copies that reach outside the written data.
//   Header, flag and literal bytes are taken while no copy runs and the
//   output register is free; a literal appears on the output the cycle
//   after acceptance. A control word's high byte starts a copy of 2 to
//   17 bytes. Each copied byte takes a history read, then the output and
//   the history write-back through the single port pair of the window
//   RAM. A copy holds off input until it ends, sooner when clipped at the
//   declared size.
//   Reset returns the parser to the size low byte; the history window is
//   not cleared, as only bytes of the current resource are ever used.
//   A stall on the output holds the output register; input is taken only
//   when the output register is free or draining in the same cycle.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top
    import lzssd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_data  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_data o_out_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    t_phase                r_phase;
    t_cp_state             r_cp_state;
    t_cp_state             n_cp_state;
    logic [SIZE_W-1:0]     r_bw;
    logic [SIZE_W-1:0]     r_target;
    logic [7:0]            r_flags;
    logic [FLAG_IDX_W-1:0] r_fidx;
    logic [7:0]            r_ctrl_lo;
    logic [DIST_W-1:0]     r_dist;
    logic [COUNT_W-1:0]    r_rem;
    logic                  r_bad;
    logic                  r_out_valid;
    t_out_data             r_out_data;

    logic              out_free;
    logic              in_acc;
    t_phase            eff_phase;
    logic              lit_emit;
    logic              cp_emit;
    logic              cp_read;
    logic              cp_last;
    logic              emit;
    logic [7:0]        emit_byte;
    logic [SIZE_W-1:0] bw_inc;
    logic [SIZE_W-1:0] rd_addr_full;
    logic [7:0]        rd_data;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_cp_state == CP_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign eff_phase  = i_in_data.starts_resource ? PH_SIZE_LO : r_phase;
    assign lit_emit   = in_acc && (eff_phase == PH_BODY) && !r_fidx[3]
                        && r_flags[r_fidx[2:0]];
    assign bw_inc     = r_bw + SIZE_W'(1);
    assign cp_last    = (r_rem == COUNT_W'(1)) || (bw_inc >= r_target);
    assign emit       = lit_emit || cp_emit;
    assign emit_byte  = lit_emit ? i_in_data.in_byte : (r_bad ? 8'd0 : rd_data);
    assign rd_addr_full = r_bw - SIZE_W'(r_dist);

    // Copy sequencer: next state.
    always_comb begin
        n_cp_state = r_cp_state;
        case (r_cp_state)
            CP_IDLE: begin
                if (in_acc && (eff_phase == PH_CTRL_HI)) begin
                    n_cp_state = CP_READ;
                end
            end
            CP_READ: n_cp_state = CP_EMIT;
            CP_EMIT: begin
                if (out_free) begin
                    n_cp_state = cp_last ? CP_IDLE : CP_READ;
                end
            end
            default: n_cp_state = CP_IDLE;
        endcase
    end

    // Copy sequencer: outputs.
    always_comb begin
        cp_read = 1'b0;
        cp_emit = 1'b0;
        case (r_cp_state)
            CP_READ: cp_read = 1'b1;
            CP_EMIT: cp_emit = out_free;
            default: begin
                cp_read = 1'b0;
                cp_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_state <= CP_IDLE;
        end else begin
            r_cp_state <= n_cp_state;
        end
    end

    // Parser and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIZE_LO;
            r_bw      <= '0;
            r_target  <= '0;
            r_flags   <= '0;
            r_fidx    <= FLAG_IDX_W'(8);
            r_ctrl_lo <= '0;
            r_dist    <= '0;
            r_rem     <= '0;
            r_bad     <= 1'b0;
        end else begin
            if (emit) begin
                r_bw <= bw_inc;
            end
            if (in_acc) begin
                case (eff_phase)
                    PH_SIZE_LO: begin
                        r_target <= {8'd0, i_in_data.in_byte};
                        r_bw     <= '0;
                        r_fidx   <= FLAG_IDX_W'(8);
                        r_flags  <= '0;
                        r_phase  <= PH_SIZE_HI;
                    end
                    PH_SIZE_HI: begin
                        r_target[15:8] <= i_in_data.in_byte;
                        r_phase        <= PH_IGN_LO;
                    end
                    PH_IGN_LO: r_phase <= PH_IGN_HI;
                    PH_IGN_HI: r_phase <= (r_target == '0) ? PH_DONE : PH_BODY;
                    PH_BODY: begin
                        if (r_fidx[3]) begin
                            r_flags <= i_in_data.in_byte;
                            r_fidx  <= '0;
                        end else if (lit_emit) begin
                            r_fidx  <= r_fidx + FLAG_IDX_W'(1);
                            r_phase <= (bw_inc >= r_target) ? PH_DONE : PH_BODY;
                        end else begin
                            r_ctrl_lo <= i_in_data.in_byte;
                            r_phase   <= PH_CTRL_HI;
                        end
                    end
                    PH_CTRL_HI: begin
                        // Phase stays here until the copy finishes.
                        r_dist <= {i_in_data.in_byte[LEN_W-1:0], r_ctrl_lo};
                        r_rem  <= COUNT_W'(i_in_data.in_byte[7:LEN_W]) + LEN_BIAS;
                        r_fidx <= r_fidx + FLAG_IDX_W'(1);
                    end
                    PH_DONE: r_phase <= PH_DONE;
                    default: r_phase <= PH_DONE;
                endcase
            end
            if (cp_read) begin
                r_bad <= (r_dist == '0) || (SIZE_W'(r_dist) > r_bw);
            end
            if (cp_emit) begin
                r_rem <= r_rem - COUNT_W'(1);
                if (cp_last) begin
                    r_phase <= (bw_inc >= r_target) ? PH_DONE : PH_BODY;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.out_byte      <= emit_byte;
            r_out_data.last_byte     <= (bw_inc == r_target);
            r_out_data.bad_reference <= cp_emit && r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lzssd_hist_ram #(
        .DEPTH(WINDOW_DEPTH)
    ) u_hist (
        .i_clk    (i_clk),
        .i_wr_en  (emit),
        .i_wr_addr(r_bw[AW-1:0]),
        .i_wr_data(emit_byte),
        .i_rd_en  (cp_read),
        .i_rd_addr(rd_addr_full[AW-1:0]),
        .o_rd_data(rd_data)
    );

    a_bw_within_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bw <= r_target)
        else $error("bytes written exceed declared size");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_reference) |-> (o_out_data.out_byte == 8'd0))
        else $error("bad reference byte not zero");

    a_copy_in_ctrl_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cp_state != CP_IDLE) |-> (r_phase == PH_CTRL_HI && r_rem != '0))
        else $error("copy running outside control phase or with no bytes left");

    a_read_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cp_state == CP_READ) |=> (r_cp_state == CP_EMIT))
        else $error("history read not followed by emit");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lzss_stream_decompressor_top. A scoreboard class
// expands each accepted compressed byte in its own copy of the decoder state.
// It holds the expected output bytes and compares every output transaction
// with the oldest one. The stimulus is a directed set of headers, literals,
// overlapping, bad and clipped copies, followed by random resources that
// include bad references and some noise. Random stalls run on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import lzssd_pkg::*;

    localparam int ITEM_GOAL      = 210;
    localparam int QUIET_FROM     = 175;
    localparam int HOLD_AT        = 70;
    localparam int DRAIN_AT       = 130;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 48;

    class decomp_scoreboard;
        logic [7:0]  window [WINDOW_DEPTH_DEF];
        logic [15:0] n_written;
        logic [15:0] size_goal;
        t_phase      phase;
        logic [7:0]  flags;
        logic [3:0]  flag_pos;
        logic [7:0]  ctrl_lo;
        t_out_data   expected_bytes [$];
        int errors, bytes_ok, items_taken, items_ignored;
        int copies, bad_refs, resources;

        function new();
            foreach (window[k]) window[k] = 8'h00;
            n_written = '0;
            size_goal = '0;
            phase     = PH_SIZE_LO;
            flags     = '0;
            flag_pos  = 4'd8;
            ctrl_lo   = '0;
        endfunction

        function void put_byte(logic [7:0] value, logic bad);
            t_out_data r;
            window[n_written[DIST_W-1:0]] = value;
            n_written = n_written + 16'd1;
            r.out_byte      = value;
            r.last_byte     = (n_written == size_goal);
            r.bad_reference = bad;
            expected_bytes.push_back(r);
        endfunction

        function void close_token();
            flag_pos = flag_pos + 4'd1;
            phase    = (n_written >= size_goal) ? PH_DONE : PH_BODY;
        endfunction

        function void take_compressed_byte(t_in_data d);
            logic [15:0] ctl;
            logic [15:0] src;
            logic [DIST_W-1:0] back_dist;
            int count;
            int j;
            if (d.starts_resource) phase = PH_SIZE_LO;
            if (phase == PH_DONE) items_ignored++;
            else items_taken++;
            case (phase)
                PH_SIZE_LO: begin
                    size_goal = {8'h00, d.in_byte};
                    n_written = '0;
                    flag_pos  = 4'd8;
                    flags     = '0;
                    phase     = PH_SIZE_HI;
                    resources++;
                end
                PH_SIZE_HI: begin
                    size_goal[15:8] = d.in_byte;
                    phase = PH_IGN_LO;
                end
                PH_IGN_LO: phase = PH_IGN_HI;
                PH_IGN_HI: phase = (size_goal == 16'd0) ? PH_DONE : PH_BODY;
                PH_BODY: begin
                    if (flag_pos >= 4'd8) begin
                        flags    = d.in_byte;
                        flag_pos = 4'd0;
                    end else if (flags[flag_pos[2:0]]) begin
                        put_byte(d.in_byte, 1'b0);
                        close_token();
                    end else begin
                        ctrl_lo = d.in_byte;
                        phase   = PH_CTRL_HI;
                    end
                end
                PH_CTRL_HI: begin
                    ctl       = {d.in_byte, ctrl_lo};
                    back_dist = ctl[DIST_W-1:0];
                    count     = int'(ctl[15:12]) + 2;
                    copies++;
                    for (j = 0; j < count && n_written < size_goal; j++) begin
                        if (back_dist == '0 || {4'h0, back_dist} > n_written) begin
                            put_byte(8'h00, 1'b1);
                            bad_refs++;
                        end else begin
                            src = n_written - {4'h0, back_dist};
                            put_byte(window[src[DIST_W-1:0]], 1'b0);
                        end
                    end
                    close_token();
                end
                default: phase = PH_DONE;
            endcase
        endfunction

        function void check_output_byte(t_out_data got);
            t_out_data want;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output: byte %02h last %0b bad %0b",
                             got.out_byte, got.last_byte, got.bad_reference);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte ||
                got.bad_reference !== want.bad_reference) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b, %s",
                             want.out_byte, got.out_byte, want.last_byte, got.last_byte,
                             $sformatf("bad_ref exp %0b got %0b",
                                       want.bad_reference, got.bad_reference));
            end else begin
                bytes_ok++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_data  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_data out_data;

    decomp_scoreboard sb;
    bit sender_gaps   = 1'b1;
    bit out_stalls    = 1'b1;
    bit long_hold_req = 1'b0;
    bit hold_done     = 1'b0;
    bit drain_done    = 1'b0;
    int idle_cycles   = 0;

    lzss_stream_decompressor_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (out_stalls && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Sample both channels on the falling edge ahead of the edge that takes the transaction.
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.take_compressed_byte(in_data);
            if (out_valid && out_ready) sb.check_output_byte(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d bytes pending",
                         idle_cycles, sb.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        t_in_data d;
        bit taken;
        d.in_byte         = b;
        d.starts_resource = start;
        taken             = 1'b0;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    // Hold input until every expected byte has come out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic send_resource();
        logic [15:0] size;
        logic [7:0]  flag;
        logic [11:0] back_dist;
        logic [3:0]  len;
        int pick, made, tokens, k, span;
        pick   = $urandom_range(0, 19);
        made   = 0;
        tokens = 0;
        if (pick == 0) size = 16'd0;
        else if (pick == 1) size = 16'($urandom_range(0, 65535));
        else if (pick <= 4) size = 16'($urandom_range(60, 200));
        else size = 16'($urandom_range(1, 40));
        send_byte(size[7:0], ($urandom_range(0, 9) != 0));
        send_byte(size[15:8], 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
        while (made < int'(size) && tokens < 40) begin
            flag = 8'($urandom);
            send_byte(flag, 1'b0);
            for (k = 0; k < 8 && made < int'(size); k++) begin
                tokens++;
                if (flag[k]) begin
                    send_byte(8'($urandom), 1'b0);
                    made++;
                end else begin
                    len  = 4'($urandom_range(0, 15));
                    pick = $urandom_range(0, 9);
                    if (pick == 0) back_dist = '0;
                    else if (pick == 1 || made == 0)
                        back_dist = 12'($urandom_range(0, 4095));
                    else back_dist = 12'($urandom_range(1, (made < 4095) ? made : 4095));
                    send_byte(back_dist[7:0], 1'b0);
                    send_byte({len, back_dist[11:8]}, 1'b0);
                    span = int'(len) + 2;
                    made += (span < int'(size) - made) ? span : int'(size) - made;
                end
                // break the token alignment now and then
                if ($urandom_range(0, 39) == 0) send_byte(8'($urandom), 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 1'b0);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size 30 without a start mark: literals, zero distance, overlapping run,
        // distance beyond the start, copy cut at the declared size, byte after end.
        send_byte(8'd30, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h77, 1'b0);
        // Zero size, then a byte that is dropped.
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        // Large size, abandoned between the two control bytes by the next start.
        send_byte(8'h05, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);

        while (sb.items_taken < ITEM_GOAL) begin
            if (!hold_done && sb.items_taken >= HOLD_AT) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            if (!drain_done && sb.items_taken >= DRAIN_AT) begin
                drain_outputs();
                drain_done = 1'b1;
            end
            if (sb.items_taken >= QUIET_FROM) begin
                sender_gaps = 1'b0;
                out_stalls  = 1'b0;
            end
            send_resource();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d compressed bytes (%0d ignored) over %0d resources",
                 sb.items_taken + sb.items_ignored, sb.items_ignored, sb.resources);
        $display("checked %0d output bytes, %0d copies, %0d bad references, %0d errors",
                 sb.bytes_ok, sb.copies, sb.bad_refs, sb.errors + sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
